// ----- src/spq_pkg.sv -----
// Package for the sorted priority queue: sizes, codes and transaction types.
`default_nettype none
package spq_pkg;

	localparam int CAPACITY       = 16;
	localparam int PRIORITY_WIDTH = 8;
	localparam int DATA_WIDTH     = 32;
	localparam int CNT_W          = $clog2(CAPACITY + 1);

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_POP_EMPTY  = 2'd1,
		ST_PUSH_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                             action;
		logic signed [DATA_WIDTH-1:0]     value;
		logic        [PRIORITY_WIDTH-1:0] priority_req;
	} request_t;

	typedef struct packed {
		status_t                          status;
		logic signed [DATA_WIDTH-1:0]     front_value;
		logic        [PRIORITY_WIDTH-1:0] front_priority;
		logic                             is_empty;
		logic        [CNT_W-1:0]          entry_count;
	} result_t;

	// One queue slot as it travels between neighbouring cells.
	typedef struct packed {
		logic                             valid;
		logic        [DATA_WIDTH-1:0]     value;
		logic        [PRIORITY_WIDTH-1:0] prio;
	} entry_t;

	// Operation broadcast to every cell in the row.
	typedef struct packed {
		logic                             push;
		logic                             pop;
		logic        [DATA_WIDTH-1:0]     value;
		logic        [PRIORITY_WIDTH-1:0] prio;
	} cell_cmd_t;

endpackage
`default_nettype wire

// ----- src/spq_cell.sv -----
// One slot of the sorted row: holds an entry and trades it with its neighbours.
`default_nettype none
module spq_cell (
	input  wire               clk,
	input  wire               arst_n,
	input  spq_pkg::cell_cmd_t cmd,
	input  spq_pkg::entry_t   left_entry,
	input  wire               left_keep,
	input  spq_pkg::entry_t   right_entry,
	output spq_pkg::entry_t   entry,
	output logic              keep
);
	import spq_pkg::*;

	logic   valid_q;
	logic   [DATA_WIDTH-1:0]     value_q;
	logic   [PRIORITY_WIDTH-1:0] prio_q;
	entry_t new_entry;
	entry_t next_entry;

	// The entry stays put on a push when it is ahead of the new one.
	assign keep = valid_q && (prio_q >= cmd.prio);

	assign entry = '{valid: valid_q, value: value_q, prio: prio_q};

	always_comb begin
		new_entry  = '{valid: 1'b1, value: cmd.value, prio: cmd.prio};
		next_entry = entry;
		if (cmd.push) begin
			if (keep) begin
				next_entry = entry;
			end else if (left_keep) begin
				next_entry = new_entry;
			end else begin
				next_entry = left_entry;
			end
		end else if (cmd.pop) begin
			next_entry = right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= next_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= next_entry.value;
		prio_q  <= next_entry.prio;
	end

endmodule
`default_nettype wire

// ----- src/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a row of cells and the result register.
// Latency: the result of a transaction is strobed on done in the cycle after it is accepted.
// Throughput: one transaction per cycle; busy stays low, as the whole row updates on the same edge.
// The rate is set by the cell row, where every cell compares and shifts in parallel.
// Reset: arst_n clears all valid bits and the count, leaving an empty queue at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module sorted_priority_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  spq_pkg::request_t  request,
	output logic               done,
	output spq_pkg::result_t   result
);
	import spq_pkg::*;

	// The row answers a transaction within the same cycle, so it is never busy.
	assign busy = 1'b0;

	logic                accept;
	logic                is_full;
	logic                is_none;
	cell_cmd_t           cmd;
	entry_t              cell_entry [CAPACITY];
	logic                cell_keep  [CAPACITY];
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_next;
	status_t             status_next;
	status_t             status_q;
	logic                done_q;

	assign accept  = start && !busy;
	assign is_full = (count_q == CNT_W'(CAPACITY));
	assign is_none = (count_q == '0);

	// A push on a full queue and a pop on an empty one leave every cell alone.
	always_comb begin
		cmd.push    = accept && (request.action == ACT_PUSH) && !is_full;
		cmd.pop     = accept && (request.action == ACT_POP) && !is_none;
		cmd.value   = request.value;
		cmd.prio    = request.priority_req;
		count_next  = count_q;
		status_next = ST_OK;
		if (request.action == ACT_PUSH) begin
			if (is_full) begin
				status_next = ST_PUSH_FULL;
			end else begin
				count_next = count_q + 1'b1;
			end
		end else begin
			if (is_none) begin
				status_next = ST_POP_EMPTY;
			end else begin
				count_next = count_q - 1'b1;
			end
		end
	end

	// The cells form a sorted row with the front at index zero. On a push each
	// cell keeps its entry, takes the new one, or takes its left neighbour's; on a
	// pop every cell takes its right neighbour's entry.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_entry;
		entry_t right_entry;
		logic   left_keep;

		if (i == 0) begin : g_head
			assign left_entry = '0;
			assign left_keep  = 1'b1;
		end else begin : g_body
			assign left_entry = cell_entry[i-1];
			assign left_keep  = cell_keep[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_entry  (left_entry),
			.left_keep   (left_keep),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q  <= count_next;
				status_q <= status_next;
			end
		end
	end

	// The front cell already holds the state after the transaction when done is
	// high, so the front fields are read straight from it.
	assign done = done_q;

	always_comb begin
		result.status         = status_q;
		result.entry_count    = count_q;
		result.is_empty       = !cell_entry[0].valid;
		result.front_value    = cell_entry[0].valid ? cell_entry[0].value : '0;
		result.front_priority = cell_entry[0].valid ? cell_entry[0].prio : '0;
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_front_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_entry[0].valid == (count_q != '0))
		else $error("front cell validity disagrees with entry count");

	a_tail_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_entry[CAPACITY-1].valid == is_full)
		else $error("last cell validity disagrees with full state");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (request.action == ACT_PUSH) && !is_full |=> count_q == $past(count_q) + 1'b1)
		else $error("accepted push did not grow the queue");

	a_rejected_holds: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != ST_OK) |-> count_q == $past(count_q))
		else $error("rejected transaction changed the queue");
`endif

endmodule
`default_nettype wire

// ----- sim/sorted_priority_queue_test.sv -----
// Self-checking testbench for the sorted priority queue: scoreboard, stimulus and checks.
module sorted_priority_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	// Cycles in which no transaction is accepted and no result is strobed before the run
	// is abandoned. The sender's idle gaps are brief, and a result follows every accepted
	// transaction in the next cycle, so this is generous.
	localparam int QUIET_LIMIT = 1000;

	// The scoreboard keeps its own sorted copy of the queue. Each accepted transaction is
	// applied to that copy and the state it leaves behind becomes the expected result.
	// Results arrive in transaction order, so a plain FIFO of expectations is enough.
	class queue_scoreboard;
		logic [DATA_WIDTH-1:0]     slot_value [CAPACITY];
		logic [PRIORITY_WIDTH-1:0] slot_prio  [CAPACITY];
		int unsigned held;
		result_t     awaited_results [$];
		int unsigned errors, checked, peak;
		int unsigned n_ok, n_pop_empty, n_push_full;

		function int unsigned pending();
			return awaited_results.size();
		endfunction

		function void note_request(request_t r);
			result_t want;
			int unsigned pos, k;
			want = '0;
			want.status = ST_OK;
			if (r.action == ACT_PUSH) begin
				if (held >= CAPACITY) begin
					want.status = ST_PUSH_FULL;
				end else begin
					// New entry goes behind everything of higher or equal priority.
					pos = 0;
					while (pos < held && slot_prio[pos] >= r.priority_req)
						pos++;
					for (k = held; k > pos; k--) begin
						slot_value[k] = slot_value[k-1];
						slot_prio[k]  = slot_prio[k-1];
					end
					slot_value[pos] = r.value;
					slot_prio[pos]  = r.priority_req;
					held++;
				end
			end else begin
				if (held == 0) begin
					want.status = ST_POP_EMPTY;
				end else begin
					for (k = 0; k + 1 < held; k++) begin
						slot_value[k] = slot_value[k+1];
						slot_prio[k]  = slot_prio[k+1];
					end
					held--;
				end
			end
			if (held == 0) begin
				want.front_value    = '0;
				want.front_priority = '0;
				want.is_empty       = 1'b1;
			end else begin
				want.front_value    = slot_value[0];
				want.front_priority = slot_prio[0];
				want.is_empty       = 1'b0;
			end
			want.entry_count = CNT_W'(held);
			case (want.status)
				ST_OK:        n_ok++;
				ST_POP_EMPTY: n_pop_empty++;
				default:      n_push_full++;
			endcase
			if (held > peak)
				peak = held;
			awaited_results.push_back(want);
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			checked++;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none outstanding, expected nothing, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("front_value", want.front_value, got.front_value);
			compare_field("front_priority", want.front_priority, got.front_priority);
			compare_field("is_empty", want.is_empty, got.is_empty);
			compare_field("entry_count", want.entry_count, got.entry_count);
		endfunction
	endclass

	logic     clk     = 1'b0;
	logic     arst_n  = 1'b0;
	logic     start   = 1'b0;
	request_t request = '0;
	logic     busy;
	logic     done;
	result_t  result;

	queue_scoreboard board = new;
	int unsigned     quiet_cycles = 0;

	sorted_priority_queue dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	// 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Monitor. Everything is sampled at the rising edge, before any of this edge's
	// nonblocking updates land, so the values seen are those of the cycle just ended.
	// A result strobed here belongs to a transaction accepted at an earlier edge, so it
	// is checked before the transaction accepted at this same edge is noted.
	always @(posedge clk) begin
		if (done)
			board.check_result(result);
		if (arst_n && start && !busy)
			board.note_request(request);
		if (done || (arst_n && start && !busy))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction accepted for %0d cycles", $time, QUIET_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic request_t make_request(logic act, logic [DATA_WIDTH-1:0] val,
			logic [PRIORITY_WIDTH-1:0] pri);
		request_t r;
		r.action       = act;
		r.value        = val;
		r.priority_req = pri;
		return r;
	endfunction

	// Presents one transaction and returns once it has been accepted. With probability
	// idle_pct the sender first drops start for a short random gap. When there is no gap, start
	// simply stays high from the previous transaction, so it is never lowered and raised
	// within the same edge.
	task automatic send_request(input request_t r, input int idle_pct);
		int gap;
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	// Holds off the sender until every outstanding result has come back. The count is
	// looked at on the falling edge, well clear of the monitor, and driving resumes on
	// the next rising edge.
	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (board.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Random transaction. The priority is drawn from a crowded range half of the time so
	// that ties, and therefore arrival order, are exercised heavily; the rest of the time
	// it is an extreme or a fully random byte. Data words are always fully random.
	function automatic request_t random_request(int push_pct);
		logic [PRIORITY_WIDTH-1:0] pri;
		case ($urandom_range(3))
			0, 1:    pri = PRIORITY_WIDTH'($urandom_range(3));
			2:       pri = $urandom_range(1) ? '1 : '0;
			default: pri = PRIORITY_WIDTH'($urandom);
		endcase
		return make_request(($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP,
			DATA_WIDTH'($urandom), pri);
	endfunction

	initial begin
		// Sender idling per random phase; the receiver cannot hold results off, so only
		// the sender side varies. Phases with no idling give back-to-back transactions.
		int       idle_levels [4];
		int       p, n, k, push_pct;
		request_t r;

		idle_levels = '{0, 45, 0, 6};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A pop on the empty queue comes first, then the data and priority
		// extremes, with equal priorities pushed so their arrival order is visible at the
		// front.
		send_request(make_request(ACT_POP, '1, '1), 0);
		send_request(make_request(ACT_PUSH, 32'h7FFF_FFFF, 8'hFF), 0);
		send_request(make_request(ACT_PUSH, 32'h8000_0000, 8'h00), 0);
		send_request(make_request(ACT_PUSH, 32'h0000_0000, 8'h00), 0);
		send_request(make_request(ACT_PUSH, 32'hFFFF_FFFF, 8'hFF), 0);
		send_request(make_request(ACT_POP, '0, '0), 0);
		send_request(make_request(ACT_POP, '0, '0), 0);
		// Two entries remain; fill the queue to capacity with spread priorities.
		for (k = 0; k < CAPACITY - 2; k++)
			send_request(make_request(ACT_PUSH,
				(k[0] ? 32'hAAAA_AAAA : 32'h5555_5555) ^ k,
				PRIORITY_WIDTH'(k * 17)), 0);
		// A push on the full queue must be dropped, even at the highest priority.
		send_request(make_request(ACT_PUSH, 32'h1234_5678, 8'hFF), 0);
		send_request(make_request(ACT_PUSH, 32'h0BAD_F00D, 8'h00), 0);
		// A pop with its ignored fields set to ones.
		send_request(make_request(ACT_POP, '1, '1), 0);
		wait_drained();

		// Random part. Within each phase the mix shifts every few dozen transactions
		// between filling, draining and balanced traffic, so the queue runs repeatedly
		// into both the full and the empty boundary. Each phase ends with the sender
		// waiting until every result is back.
		for (p = 0; p < 4; p++) begin
			push_pct = 50;
			for (n = 0; n < 257; n++) begin
				if (n % 32 == 0) begin
					case ($urandom_range(2))
						0:       push_pct = 85;
						1:       push_pct = 15;
						default: push_pct = 50;
					endcase
				end
				r = random_request(push_pct);
				send_request(r, (n % 64 < 16) ? 0 : idle_levels[p]);
			end
			wait_drained();
		end

		// Let a stray result show itself if the block produces one.
		repeat (4) @(posedge clk);

		$display("Run covered %0d transactions: %0d ok, %0d pops on empty, %0d pushes on full.",
			board.checked, board.n_ok, board.n_pop_empty, board.n_push_full);
		$display("Occupancy reached %0d of %0d; sender idling 0, 45 and 6 in a hundred.",
			board.peak, CAPACITY);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results outstanding", board.errors,
				board.pending());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
